### rtl/cse_pkg.sv
// Shared types, widths and microcode for the Chebyshev series evaluator.
package cse_pkg;

  // Field widths of the transfer payloads.
  localparam int COEF_W  = 32;
  localparam int X_W     = 18;
  localparam int IDX_W   = 6;
  localparam int DEG_W   = 6;

  // Fixed-point layout: x carries this many fraction bits.
  localparam int X_FRAC_BITS = 16;

  // Datapath widths: accumulator, full product, rounded product, wide sum.
  localparam int ACC_W  = 48;
  localparam int PROD_W = ACC_W + X_W;
  localparam int MX_W   = ACC_W + 1;
  localparam int SUM_W  = ACC_W + 3;

  localparam logic signed [X_W-1:0] X_ONE     = X_W'(1 << X_FRAC_BITS);
  localparam logic signed [X_W-1:0] X_NEG_ONE = -X_ONE;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // Rounding bias for dropping the x fraction bits.
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (X_FRAC_BITS - 1));

  // Operation codes of an input transfer.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Configuration port: byte address width and register index.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_DEGREE = 1'b0;

  // Microcode addresses.
  typedef logic [2:0] upc_t;
  localparam upc_t UA_IDLE  = 3'd0;
  localparam upc_t UA_INIT  = 3'd1;
  localparam upc_t UA_L_MUL = 3'd2;
  localparam upc_t UA_L_ACC = 3'd3;
  localparam upc_t UA_F_MUL = 3'd4;
  localparam upc_t UA_F_SUM = 3'd5;

  // Jump conditions of a control word.
  typedef enum logic [2:0] {
    C_NEVER       = 3'd0,
    C_EVAL_TAKEN  = 3'd1,
    C_TOP_ZERO    = 3'd2,
    C_CNT_NOT_ONE = 3'd3,
    C_OUT_FREE    = 3'd4
  } cond_t;

  // One control word: datapath strobes plus sequencing.
  typedef struct packed {
    logic  ready;
    logic  init;
    logic  mul;
    logic  acc;
    logic  fin;
    cond_t cond;
    upc_t  target;
    logic  hold;
  } ctrl_word_t;

  // Control store. Jump to target when the condition holds, otherwise
  // hold or advance to the next word.
  function automatic ctrl_word_t ucode(upc_t addr);
    ctrl_word_t w;
    w = '0;
    unique case (addr)
      UA_IDLE: begin
        w.ready = 1'b1; w.cond = C_EVAL_TAKEN; w.target = UA_INIT; w.hold = 1'b1;
      end
      UA_INIT: begin
        w.init = 1'b1; w.cond = C_TOP_ZERO; w.target = UA_F_MUL;
      end
      UA_L_MUL: begin
        w.mul = 1'b1; w.cond = C_NEVER; w.target = UA_IDLE;
      end
      UA_L_ACC: begin
        w.acc = 1'b1; w.cond = C_CNT_NOT_ONE; w.target = UA_L_MUL;
      end
      UA_F_MUL: begin
        w.mul = 1'b1; w.cond = C_NEVER; w.target = UA_IDLE;
      end
      UA_F_SUM: begin
        w.fin = 1'b1; w.cond = C_OUT_FREE; w.target = UA_IDLE; w.hold = 1'b1;
      end
      default: begin
        w.cond = C_NEVER; w.target = UA_IDLE; w.hold = 1'b0;
        w.cond = C_EVAL_TAKEN; w.cond = C_NEVER;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/cse_if.sv
// Valid/ready channel interfaces for the input and result transfers.
interface cse_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [cse_pkg::IDX_W-1:0]           coef_index;
  logic signed [cse_pkg::COEF_W-1:0]   coef_value;
  logic signed [cse_pkg::X_W-1:0]      x_value;

  modport source (output valid, operation, coef_index, coef_value, x_value, input ready);
  modport sink   (input valid, operation, coef_index, coef_value, x_value, output ready);
endinterface

interface cse_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cse_pkg::COEF_W-1:0]   series_value;
  logic                                saturated;

  modport source (output valid, series_value, saturated, input ready);
  modport sink   (input valid, series_value, saturated, output ready);
endinterface

### rtl/chebyshev_series_evaluator_unit.sv
// Clenshaw evaluator of a Chebyshev series, driven by a microcoded sequencer.
// Write transfers are taken back to back, one per cycle, while the sequencer is idle. An evaluate
// transfer with top term T (degree limited to MAX_TERMS-1) shows its result, and input ready
// returns in that cycle; no new transfer is taken while it is evaluated, as the two-step loop
// per term runs on the one shared multiplier and a stalled result holds the sequencer.
// Synchronous active-low reset clears sequencer, degree and output valid, not the memory.
module chebyshev_series_evaluator_unit #(
  parameter int MAX_TERMS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  cse_in_if.sink                               in_if,
  cse_out_if.source                            out_if,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cse_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [cse_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [cse_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = (AW > cse_pkg::DEG_W) ? AW : cse_pkg::DEG_W;
  localparam logic [CW-1:0] TOP_LIMIT = CW'(MAX_TERMS - 1);

  // Sequencer and control word.
  cse_pkg::upc_t       upc_r, upc_nxt;
  cse_pkg::ctrl_word_t ctl;
  logic                cond_true;

  // Configuration and datapath state.
  logic [cse_pkg::DEG_W-1:0]          degree_r;
  logic [AW-1:0]                      cnt_r;
  logic signed [cse_pkg::X_W-1:0]     xc_r;
  logic signed [cse_pkg::ACC_W-1:0]   b1_r, b2_r;
  logic signed [cse_pkg::PROD_W-1:0]  prod_r;
  logic signed [cse_pkg::COEF_W-1:0]  rd_data_r;
  logic signed [cse_pkg::COEF_W-1:0]  coef_mem [MAX_TERMS];

  // Output register.
  logic                               out_valid_r, out_valid_nxt;
  logic signed [cse_pkg::COEF_W-1:0]  series_r;
  logic                               sat_r;

  logic                               in_xfer, eval_taken, mem_we, out_free, fin_fire;
  logic [CW-1:0]                      deg_ext, top_sel, idx_ext;
  logic signed [cse_pkg::X_W-1:0]     x_clamped;
  logic signed [cse_pkg::PROD_W-1:0]  prod_full, rnd_sum;
  logic signed [cse_pkg::MX_W-1:0]    mx;
  logic signed [cse_pkg::SUM_W-1:0]   b_sum, r_sum;
  logic signed [cse_pkg::ACC_W-1:0]   b_sat;
  logic signed [cse_pkg::COEF_W-1:0]  r_sat;
  logic                               r_clip;
  logic                               cfg_wr;

  // Control word fetch and handshake decode.
  assign ctl        = cse_pkg::ucode(upc_r);
  assign in_if.ready = ctl.ready;
  assign in_xfer    = in_if.valid && ctl.ready;
  assign eval_taken = in_xfer && (in_if.operation == cse_pkg::OP_EVAL);
  assign out_free   = !out_valid_r || out_if.ready;
  assign fin_fire   = ctl.fin && out_free;

  // Top term index, limited to the memory depth.
  assign deg_ext = CW'(degree_r);
  assign top_sel = (deg_ext > TOP_LIMIT) ? TOP_LIMIT : deg_ext;

  // Coefficient writes beyond the memory depth are dropped.
  assign idx_ext = CW'(in_if.coef_index);
  assign mem_we  = in_xfer && (in_if.operation == cse_pkg::OP_WRITE) && (idx_ext <= TOP_LIMIT);

  // Jump condition select.
  always_comb begin
    unique case (ctl.cond)
      cse_pkg::C_NEVER:       cond_true = 1'b0;
      cse_pkg::C_EVAL_TAKEN:  cond_true = eval_taken;
      cse_pkg::C_TOP_ZERO:    cond_true = (top_sel == '0);
      cse_pkg::C_CNT_NOT_ONE: cond_true = (cnt_r != AW'(1));
      cse_pkg::C_OUT_FREE:    cond_true = out_free;
      default:                cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      upc_nxt = ctl.target;
    end else if (ctl.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= cse_pkg::UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Clamp x to plus or minus one.
  always_comb begin
    if (in_if.x_value > cse_pkg::X_ONE) begin
      x_clamped = cse_pkg::X_ONE;
    end else if (in_if.x_value < cse_pkg::X_NEG_ONE) begin
      x_clamped = cse_pkg::X_NEG_ONE;
    end else begin
      x_clamped = in_if.x_value;
    end
  end

  // Coefficient memory with a registered read at the term counter.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      coef_mem[idx_ext[AW-1:0]] <= in_if.coef_value;
    end
    rd_data_r <= coef_mem[cnt_r];
  end

  // Shared multiplier: product of b1 and the clamped x.
  assign prod_full = cse_pkg::PROD_W'(b1_r) * cse_pkg::PROD_W'(xc_r);

  // Drop the x fraction bits, rounding the magnitude half away from zero.
  assign rnd_sum = prod_r + (prod_r[cse_pkg::PROD_W-1] ? (cse_pkg::RND_HALF - 1'b1)
                                                        : cse_pkg::RND_HALF);
  assign mx = rnd_sum[cse_pkg::X_FRAC_BITS +: cse_pkg::MX_W];

  // Recurrence step: b = 2*x*b1 - b2 + c[i], saturated to the accumulator range.
  assign b_sum = (cse_pkg::SUM_W'(mx) <<< 1) - cse_pkg::SUM_W'(b2_r)
               + cse_pkg::SUM_W'(rd_data_r);
  always_comb begin
    if (b_sum > cse_pkg::SUM_W'(cse_pkg::ACC_MAX)) begin
      b_sat = cse_pkg::ACC_MAX;
    end else if (b_sum < cse_pkg::SUM_W'(cse_pkg::ACC_MIN)) begin
      b_sat = cse_pkg::ACC_MIN;
    end else begin
      b_sat = b_sum[cse_pkg::ACC_W-1:0];
    end
  end

  // Final step: c[0] + x*b1 - b2, saturated to the result format.
  assign r_sum = cse_pkg::SUM_W'(rd_data_r) + cse_pkg::SUM_W'(mx) - cse_pkg::SUM_W'(b2_r);
  always_comb begin
    r_clip = 1'b1;
    if (r_sum > cse_pkg::SUM_W'(cse_pkg::COEF_MAX)) begin
      r_sat = cse_pkg::COEF_MAX;
    end else if (r_sum < cse_pkg::SUM_W'(cse_pkg::COEF_MIN)) begin
      r_sat = cse_pkg::COEF_MIN;
    end else begin
      r_sat  = r_sum[cse_pkg::COEF_W-1:0];
      r_clip = 1'b0;
    end
  end

  // Datapath registers, strobed by the control word.
  always_ff @(posedge clk) begin
    if (eval_taken) begin
      xc_r <= x_clamped;
    end
    if (ctl.init) begin
      b1_r  <= '0;
      b2_r  <= '0;
      cnt_r <= top_sel[AW-1:0];
    end
    if (ctl.mul) begin
      prod_r <= prod_full;
    end
    if (ctl.acc) begin
      b2_r  <= b1_r;
      b1_r  <= b_sat;
      cnt_r <= cnt_r - 1'b1;
    end
    if (fin_fire) begin
      series_r <= r_sat;
      sat_r    <= r_clip;
    end
  end

  // Output valid: set by the final step, cleared by a transfer.
  always_comb begin
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.series_value = series_r;
  assign out_if.saturated    = sat_r;

  // Configuration port: degree register at register index zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[cse_pkg::CFG_ADDR_W-1:2] == cse_pkg::REG_DEGREE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
    end else if (cfg_wr) begin
      degree_r <= pwdata[cse_pkg::DEG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[cse_pkg::CFG_ADDR_W-1:2] == cse_pkg::REG_DEGREE) begin
      prdata = cse_pkg::CFG_DATA_W'(degree_r);
    end else begin
      prdata = '0;
    end
  end

endmodule

### rtl/cse_checker.sv
// Port-level assertions for the Chebyshev series evaluator and their bind.
module cse_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_operation,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [cse_pkg::COEF_W-1:0] out_series_value,
  input logic                              out_saturated
);

  // Reset leaves no result pending.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted evaluation occupies the sequencer for the next cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == cse_pkg::OP_EVAL) |=> !in_ready)
    else $error("input taken right after an evaluation");

  // A new result only appears after a busy cycle of the sequencer.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without evaluation work");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_series_value) &&
                                $stable(out_saturated))
    else $error("stalled result changed");

endmodule

bind chebyshev_series_evaluator_unit cse_checker u_cse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_operation     (in_if.operation),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_series_value (out_if.series_value),
  .out_saturated    (out_if.saturated)
);
